// ----- rtl/core/tcs_pkg.sv -----
`default_nettype none

package tcs_pkg;

    // request codes
    localparam logic [2:0] REQ_PUT_CURSOR = 3'd0;
    localparam logic [2:0] REQ_PUT_AT     = 3'd1;
    localparam logic [2:0] REQ_SET_CURSOR = 3'd2;
    localparam logic [2:0] REQ_CLEAR      = 3'd3;
    localparam logic [2:0] REQ_READ       = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ATTR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR = 2'd1;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [7:0] FILL_ATTR_RST  = 8'h07;
    localparam logic [7:0] CLEAR_ATTR_RST = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
    } cell_t;

    typedef struct packed {
        logic       go;
        logic       scroll;
        logic [7:0] attr;
    } sweep_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcs_if.sv -----
`default_nettype none

interface tcs_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [7:0] attr;

    modport source (output valid, output req_type, output row, output col,
                    output ch, output attr, input ready);
    modport sink   (input valid, input req_type, input row, input col,
                    input ch, input attr, output ready);
endinterface

interface tcs_res_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
    logic        out_of_range;

    modport source (output valid, output cursor_pos, output cell_char,
                    output cell_attr, output scrolled, output out_of_range,
                    input ready);
    modport sink   (input valid, input cursor_pos, input cell_char,
                    input cell_attr, input scrolled, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcs_ram.sv -----
`default_nettype none

module tcs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tcs_sweep.sv -----
`default_nettype none

module tcs_sweep #(
    parameter int unsigned ROWS = 25,
    parameter int unsigned COLS = 80
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tcs_pkg::sweep_cmd_t                 cmd,
    output logic                                     busy,
    output logic                                     we,
    output logic [$clog2(ROWS*COLS)-1:0]             waddr,
    output tcs_pkg::cell_t                           wdata,
    output logic                                     re,
    output logic [$clog2(ROWS*COLS)-1:0]             raddr,
    input  wire tcs_pkg::cell_t                      rdata
);

    import tcs_pkg::*;

    localparam int unsigned NCELLS = ROWS * COLS;
    localparam int unsigned POS_W  = $clog2(NCELLS);
    localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLS);
    localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(NCELLS - 1);
    localparam logic [POS_W-1:0] LAST_COPY  = POS_W'(NCELLS - COLS - 1);
    localparam logic [POS_W-1:0] LAST_ROW_0 = POS_W'(NCELLS - COLS);

    typedef enum logic [3:0] {
        SW_IDLE  = 4'b0001,
        SW_COPY  = 4'b0010,
        SW_DRAIN = 4'b0100,
        SW_FILL  = 4'b1000
    } sw_state_t;

    sw_state_t        state_reg, state_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [7:0]       attr_reg, attr_next;
    logic             pend_reg, pend_next;
    logic [POS_W-1:0] pend_addr_reg, pend_addr_next;

    // comes out of reset already blanking the screen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_FILL;
            idx_reg   <= '0;
            attr_reg  <= 8'h00;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            attr_reg  <= attr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        attr_next      = attr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rdata;
        re             = 1'b0;
        raddr          = idx_reg + COLS_P;
        unique case (state_reg)
            SW_IDLE:
            begin
                if (cmd.go)
                begin
                    attr_next  = cmd.attr;
                    idx_next   = '0;
                    state_next = cmd.scroll ? SW_COPY : SW_FILL;
                end
            end
            SW_COPY:
            begin
                // read one row ahead, write the previous beat's data
                re             = 1'b1;
                we             = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                if (idx_reg == LAST_COPY)
                begin
                    state_next = SW_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            SW_DRAIN:
            begin
                we         = 1'b1;
                pend_next  = 1'b0;
                idx_next   = LAST_ROW_0;
                state_next = SW_FILL;
            end
            SW_FILL:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = '{ch: SPACE_CHAR, attr: attr_reg};
                if (idx_reg == LAST_CELL)
                begin
                    state_next = SW_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != SW_IDLE);

    a_copy_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SW_COPY && pend_reg) |-> (pend_addr_reg < raddr))
        else $error("scroll write overtook its read");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (waddr <= LAST_CELL))
        else $error("sweep write beyond the screen");

    a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SW_DRAIN) |-> pend_reg)
        else $error("drain without a pending copy");

endmodule

`default_nettype wire

// ----- rtl/core/text_console_scroller_unit.sv -----
`default_nettype none

// text console, ROWS x COLS cells of {char, attr} plus one cursor
// req channel: one request per beat (put at cursor, put at row/col,
// set cursor, clear, read cell); res channel: exactly one result per request
// cfg port: cfg_we/cfg_index/cfg_wdata, index 0 fill_attr, 1 clear_attr
// put, put at row/col, set cursor and unused codes: result goes via S_DONE
// to the output register; a new request is taken once it has moved there
// read cell: also passes S_READ, which captures the registered cell ram data
// clear: the sweep engine blanks the screen, one cell written per cycle
// a scroll (put past the last cell or newline on the last row) walks the ram
// once, copying each cell one row up and blanking the bottom row
// after reset a blanking pass writes every cell, and req.ready stays low
// until it ends
// the result sits in an output register, so the next request is taken while
// the receiver stalls; a second result waits inside until that register frees
module text_console_scroller_unit #(
    parameter int unsigned ROWS = 25,
    parameter int unsigned COLS = 80
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tcs_req_if.sink                                req,
    tcs_res_if.source                              res,
    input  wire logic                              cfg_we,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                        cfg_wdata
);

    import tcs_pkg::*;

    localparam int unsigned NCELLS = ROWS * COLS;
    localparam int unsigned POS_W  = $clog2(NCELLS);
    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned COL_W  = $clog2(COLS);
    localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLS);
    localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(NCELLS - 1);
    localparam logic [POS_W-1:0] LAST_ROW_0 = POS_W'(NCELLS - COLS);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLS - 1);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
        logic       oor;
    } res_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        res_t        r;
    } out_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] cur_pos_reg, cur_pos_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [7:0]       fill_attr_reg, clear_attr_reg;
    res_t             res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;

    logic             accept;
    logic             coord_ok;
    logic [ROW_W-1:0] tgt_row;
    logic [COL_W-1:0] tgt_col;
    logic [POS_W-1:0] tgt_pos;
    logic [POS_W+10:0] cur_ext;

    sweep_cmd_t       sweep_cmd;
    logic             sweep_busy;
    logic             sw_we, sw_re;
    logic [POS_W-1:0] sw_waddr, sw_raddr;
    cell_t            sw_wdata;

    logic             top_we, top_re;
    logic [POS_W-1:0] top_waddr;
    cell_t            top_wdata;

    logic             ram_we, ram_re;
    logic [POS_W-1:0] ram_waddr, ram_raddr;
    cell_t            ram_wdata, ram_rdata;

    tcs_sweep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sweep_cmd),
        .busy  (sweep_busy),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr),
        .rdata (ram_rdata)
    );

    tcs_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (NCELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the sweep engine owns the ram while busy; requests only touch it in idle
    assign ram_we    = sweep_busy ? sw_we    : top_we;
    assign ram_waddr = sweep_busy ? sw_waddr : top_waddr;
    assign ram_wdata = sweep_busy ? sw_wdata : top_wdata;
    assign ram_re    = sweep_busy ? sw_re    : top_re;
    assign ram_raddr = sweep_busy ? sw_raddr : tgt_pos;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign coord_ok = (32'(req.row) < ROWS) && (32'(req.col) < COLS);
    assign tgt_row  = req.row[ROW_W-1:0];
    assign tgt_col  = req.col[COL_W-1:0];
    assign tgt_pos  = POS_W'(tgt_row) * COLS_P + POS_W'(tgt_col);
    assign cur_ext  = {11'b0, cur_pos_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cur_pos_reg    <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            fill_attr_reg  <= FILL_ATTR_RST;
            clear_attr_reg <= CLEAR_ATTR_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_pos_reg   <= cur_pos_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_FILL_ATTR)
            begin
                fill_attr_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_CLEAR_ATTR)
            begin
                clear_attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_pos_next   = cur_pos_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        top_we         = 1'b0;
        top_re         = 1'b0;
        top_waddr      = tgt_pos;
        top_wdata      = '{ch: req.ch, attr: req.attr};
        sweep_cmd      = '{go: 1'b0, scroll: 1'b1, attr: fill_attr_reg};
        unique case (state_reg)
            S_INIT:
            begin
                if (!sweep_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (req.req_type)
                        REQ_PUT_CURSOR:
                        begin
                            if (req.ch == NEWLINE_CHAR)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    cur_pos_next      = LAST_ROW_0;
                                    sweep_cmd.go      = 1'b1;
                                    res_next.scrolled = 1'b1;
                                    state_next        = S_SWEEP;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    cur_pos_next = cur_pos_reg - POS_W'(cur_col_reg) + COLS_P;
                                end
                            end
                            else
                            begin
                                top_we    = 1'b1;
                                top_waddr = cur_pos_reg;
                                if (cur_pos_reg == LAST_CELL)
                                begin
                                    cur_col_next      = '0;
                                    cur_pos_next      = LAST_ROW_0;
                                    sweep_cmd.go      = 1'b1;
                                    res_next.scrolled = 1'b1;
                                    state_next        = S_SWEEP;
                                end
                                else if (cur_col_reg == LAST_COL)
                                begin
                                    cur_col_next = '0;
                                    cur_row_next = cur_row_reg + 1'b1;
                                    cur_pos_next = cur_pos_reg + 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                    cur_pos_next = cur_pos_reg + 1'b1;
                                end
                            end
                        end
                        REQ_PUT_AT:
                        begin
                            top_we       = coord_ok;
                            res_next.oor = !coord_ok;
                        end
                        REQ_SET_CURSOR:
                        begin
                            res_next.oor = !coord_ok;
                            if (coord_ok)
                            begin
                                cur_row_next = tgt_row;
                                cur_col_next = tgt_col;
                                cur_pos_next = tgt_pos;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            sweep_cmd    = '{go: 1'b1, scroll: 1'b0, attr: clear_attr_reg};
                            cur_row_next = '0;
                            cur_col_next = '0;
                            cur_pos_next = '0;
                            state_next   = S_SWEEP;
                        end
                        REQ_READ:
                        begin
                            res_next.oor = !coord_ok;
                            if (coord_ok)
                            begin
                                top_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.cell_char = ram_rdata.ch;
                res_next.cell_attr = ram_rdata.attr;
                state_next         = S_DONE;
            end
            S_SWEEP:
            begin
                if (!sweep_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{cursor_pos: cur_ext[10:0], r: res_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.valid        = out_valid_reg;
    assign res.cursor_pos   = out_reg.cursor_pos;
    assign res.cell_char    = out_reg.r.cell_char;
    assign res.cell_attr    = out_reg.r.cell_attr;
    assign res.scrolled     = out_reg.r.scrolled;
    assign res.out_of_range = out_reg.r.oor;

    a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
        cur_pos_reg == POS_W'(cur_row_reg) * COLS_P + POS_W'(cur_col_reg))
        else $error("linear cursor out of step with row and column");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLS))
        else $error("cursor off the screen");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_busy |-> !accept)
        else $error("request taken while the ram is being swept");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_DONE))
        else $error("read result not captured after one cycle");

endmodule

`default_nettype wire

// ----- tb/sv/text_console_scroller_unit_test.sv -----
`timescale 1ns / 1ps

import tcs_pkg::*;

localparam int unsigned ROWS   = 25;
localparam int unsigned COLS   = 80;
localparam int unsigned NCELLS = ROWS * COLS;

// codes the block must ignore
localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
    logic        out_of_range;
} console_result_t;

class console_scoreboard;
    logic [7:0]      char_mem [NCELLS];
    logic [7:0]      attr_mem [NCELLS];
    int unsigned     cursor;
    logic [7:0]      fill_attr;
    logic [7:0]      clear_attr;
    console_result_t expected_results [$];
    int unsigned     checked;

    function new();
        fill_attr  = FILL_ATTR_RST;
        clear_attr = CLEAR_ATTR_RST;
        blank(8'h00);
        cursor  = 0;
        checked = 0;
    endfunction

    function void blank(input logic [7:0] a);
        for (int i = 0; i < NCELLS; i++)
        begin
            char_mem[i] = SPACE_CHAR;
            attr_mem[i] = a;
        end
    endfunction

    function void scroll_up();
        for (int i = COLS; i < NCELLS; i++)
        begin
            char_mem[i - COLS] = char_mem[i];
            attr_mem[i - COLS] = attr_mem[i];
        end
        for (int i = (ROWS - 1) * COLS; i < NCELLS; i++)
        begin
            char_mem[i] = SPACE_CHAR;
            attr_mem[i] = fill_attr;
        end
    endfunction

    function void set_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        if (idx == CFG_FILL_ATTR)
            fill_attr = val;
        else if (idx == CFG_CLEAR_ATTR)
            clear_attr = val;
    endfunction

    // predicts the result of one accepted request; returns 1 when it was not ignored
    function bit note_request(input logic [2:0] kind, input logic [4:0] r,
                              input logic [6:0] c, input logic [7:0] ch,
                              input logic [7:0] attr_v);
        bit              in_range;
        int unsigned     pos;
        int unsigned     line;
        console_result_t res;
        in_range = (r < ROWS) && (c < COLS);
        pos      = r * COLS + c;
        res      = '0;
        if (cursor >= NCELLS)
            cursor = 0;
        case (kind)
            REQ_PUT_CURSOR:
            begin
                if (ch == NEWLINE_CHAR)
                begin
                    line = cursor / COLS;
                    if (line == ROWS - 1)
                    begin
                        scroll_up();
                        res.scrolled = 1'b1;
                    end
                    else
                        line++;
                    cursor = line * COLS;
                end
                else
                begin
                    char_mem[cursor] = ch;
                    attr_mem[cursor] = attr_v;
                    cursor++;
                    if (cursor >= NCELLS)
                    begin
                        scroll_up();
                        res.scrolled = 1'b1;
                        cursor = (ROWS - 1) * COLS;
                    end
                end
            end
            REQ_PUT_AT:
            begin
                if (in_range)
                begin
                    char_mem[pos] = ch;
                    attr_mem[pos] = attr_v;
                end
                else
                    res.out_of_range = 1'b1;
            end
            REQ_SET_CURSOR:
            begin
                if (in_range)
                    cursor = pos;
                else
                    res.out_of_range = 1'b1;
            end
            REQ_CLEAR:
            begin
                blank(clear_attr);
                cursor = 0;
            end
            REQ_READ:
            begin
                if (in_range)
                begin
                    res.cell_char = char_mem[pos];
                    res.cell_attr = attr_mem[pos];
                end
                else
                    res.out_of_range = 1'b1;
            end
            default: ;
        endcase
        res.cursor_pos = cursor[10:0];
        expected_results.push_back(res);
        return !res.out_of_range && (kind <= REQ_READ);
    endfunction

    function bit check_result(input console_result_t got, output string why);
        console_result_t want;
        why = "";
        if (expected_results.size() == 0)
        begin
            why = $sformatf("result with nothing expected: %p", got);
            return 0;
        end
        want = expected_results.pop_front();
        checked++;
        if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
            got.cell_attr !== want.cell_attr || got.scrolled !== want.scrolled ||
            got.out_of_range !== want.out_of_range)
        begin
            why = $sformatf({"result %0d (got/want): cursor_pos %0d/%0d char %h/%h ",
                             "attr %h/%h scrolled %b/%b out_of_range %b/%b"},
                            checked, got.cursor_pos, want.cursor_pos, got.cell_char,
                            want.cell_char, got.cell_attr, want.cell_attr, got.scrolled,
                            want.scrolled, got.out_of_range, want.out_of_range);
            return 0;
        end
        return 1;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    function void flush();
        expected_results.delete();
    endfunction
endclass

module text_console_scroller_unit_test;
    localparam int unsigned DRAIN_LIMIT = 100000;
    localparam int unsigned HOLD_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;

    tcs_req_if req_ch ();
    tcs_res_if res_ch ();

    console_scoreboard sb = new();

    int unsigned mismatch_count = 0;
    int unsigned applied_count  = 0;
    int unsigned send_idle_pct  = 16;
    int unsigned recv_idle_pct  = 88;
    bit          hold_armed     = 1'b0;
    logic [4:0]  last_row       = '0;

    text_console_scroller_unit #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("text_console_scroller_unit: mismatch");
        $finish;
    end

    task automatic report(input string msg);
        if (mismatch_count < 40)
            $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_left  = HOLD_CYCLES;
                hold_armed = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        string           why;
        console_result_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (sb.note_request(req_ch.req_type, req_ch.row, req_ch.col,
                                    req_ch.ch, req_ch.attr))
                    applied_count++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.cursor_pos   = res_ch.cursor_pos;
                got.cell_char    = res_ch.cell_char;
                got.cell_attr    = res_ch.cell_attr;
                got.scrolled     = res_ch.scrolled;
                got.out_of_range = res_ch.out_of_range;
                if (!sb.check_result(got, why))
                    report(why);
            end
        end
    end

    task automatic send(input logic [2:0] kind, input logic [4:0] r, input logic [6:0] c,
                        input logic [7:0] ch, input logic [7:0] attr_v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.row      <= r;
        req_ch.col      <= c;
        req_ch.ch       <= ch;
        req_ch.attr     <= attr_v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        // let the last accepted beat reach the scoreboard first
        @(posedge clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            report($sformatf("%0d results never arrived", sb.pending()));
            sb.flush();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic pick_coord(input int unsigned oor_pct, output logic [4:0] r,
                              output logic [6:0] c);
        r = 5'($urandom_range(ROWS - 1));
        c = 7'($urandom_range(COLS - 1));
        if ($urandom_range(99) < oor_pct)
        begin
            case ($urandom_range(2))
                0: r = 5'($urandom_range(31, ROWS));
                1: c = 7'($urandom_range(127, COLS));
                default:
                begin
                    r = 5'($urandom_range(31, ROWS));
                    c = 7'($urandom_range(127, COLS));
                end
            endcase
        end
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned goal;
        int unsigned pick;
        int unsigned n;
        logic [4:0]  r;
        logic [6:0]  c;
        logic [7:0]  ch;
        goal = applied_count + quota;
        send(REQ_CLEAR, 5'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
        while (applied_count < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // a line of text from a chosen start, often on the bottom row
                r = ($urandom_range(9) < 4) ? 5'(ROWS - 1) : 5'($urandom_range(ROWS - 1));
                c = $urandom_range(1) ? 7'($urandom_range(COLS - 1))
                                      : 7'($urandom_range(COLS - 1, COLS - 10));
                last_row = r;
                send(REQ_SET_CURSOR, r, c, 8'($urandom), 8'($urandom));
                n = $urandom_range(20, 3);
                for (int k = 0; k < n; k++)
                begin
                    pick = $urandom_range(99);
                    ch = (pick < 12) ? NEWLINE_CHAR :
                         (pick < 85) ? 8'($urandom_range(8'h7E, 8'h20)) : 8'($urandom);
                    send(REQ_PUT_CURSOR, 5'($urandom), 7'($urandom), ch, 8'($urandom));
                end
            end
            else if (pick < 60)
            begin
                pick_coord(20, r, c);
                send(REQ_PUT_AT, r, c, 8'($urandom), 8'($urandom));
            end
            else if (pick < 80)
            begin
                pick_coord(15, r, c);
                if ($urandom_range(1) && r < ROWS)
                    r = last_row;
                send(REQ_READ, r, c, 8'($urandom), 8'($urandom));
            end
            else if (pick < 90)
            begin
                pick_coord(20, r, c);
                send(REQ_SET_CURSOR, r, c, 8'($urandom), 8'($urandom));
            end
            else if (pick < 95)
                send(3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)), 5'($urandom),
                     7'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 97)
                send(REQ_CLEAR, 5'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
            else
            begin
                // put at the very last cell
                send(REQ_SET_CURSOR, 5'(ROWS - 1), 7'(COLS - 1), 8'($urandom), 8'($urandom));
                ch = 8'($urandom);
                if (ch == NEWLINE_CHAR)
                    ch = SPACE_CHAR;
                send(REQ_PUT_CURSOR, 5'($urandom), 7'($urandom), ch, 8'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.row      = '0;
        req_ch.col      = '0;
        req_ch.ch       = '0;
        req_ch.attr     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        send(REQ_READ,       0,   0,  8'h00,        8'h00);
        send(REQ_PUT_CURSOR, 0,   0,  8'h41,        8'h1F);
        send(REQ_READ,       0,   0,  8'h00,        8'h00);
        send(REQ_PUT_CURSOR, 0,   0,  NEWLINE_CHAR, 8'hFF);
        send(REQ_PUT_AT,     24,  79, 8'hFF,        8'hFF);
        send(REQ_READ,       24,  79, 8'h00,        8'h00);
        send(REQ_PUT_AT,     0,   1,  8'h00,        8'h00);
        send(REQ_READ,       0,   1,  8'hFF,        8'hFF);
        send(REQ_SET_CURSOR, 31,  127, 8'h00,       8'h00);
        send(REQ_PUT_AT,     25,  0,  8'h55,        8'hAA);
        send(REQ_READ,       0,   80, 8'h00,        8'h00);
        send(REQ_READ,       31,  127, 8'h00,       8'h00);
        send(REQ_SET_CURSOR, 24,  0,  8'h00,        8'h00);
        send(REQ_PUT_CURSOR, 31,  127, NEWLINE_CHAR, 8'h00);
        send(REQ_READ,       23,  79, 8'h00,        8'h00);
        send(REQ_READ,       24,  5,  8'h00,        8'h00);
        send(REQ_SET_CURSOR, 24,  79, 8'h00,        8'h00);
        send(REQ_PUT_CURSOR, 0,   0,  8'h5A,        8'h80);
        send(REQ_READ,       23,  79, 8'h00,        8'h00);
        send(REQ_UNUSED_LO,  3,   3,  8'h12,        8'h34);
        send(REQ_UNUSED_HI,  31,  127, 8'hFF,       8'hFF);
        send(REQ_CLEAR,      31,  127, 8'hFF,       8'hFF);
        send(REQ_READ,       12,  40, 8'h00,        8'h00);
        send(REQ_PUT_CURSOR, 0,   0,  NEWLINE_CHAR, 8'h00);
        send(REQ_READ,       24,  0,  8'h00,        8'h00);
        drain();

        write_reg(CFG_FILL_ATTR, 8'hFF);
        write_reg(CFG_CLEAR_ATTR, 8'hFF);
        run_random(285);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 16;
        write_reg(CFG_FILL_ATTR, 8'h00);
        write_reg(CFG_CLEAR_ATTR, 8'($urandom));
        run_random(285);
        drain();

        // no idling, one long receiver hold-off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_FILL_ATTR, 8'($urandom));
        write_reg(CFG_CLEAR_ATTR, 8'($urandom));
        hold_armed = 1'b1;
        run_random(280);
        drain();

        if (mismatch_count == 0)
            $display("text_console_scroller_unit: match");
        else
            $display("text_console_scroller_unit: mismatch");
        $finish;
    end
endmodule
